>>> rtl/fpa_pkg.sv
// ----------------------------------------------------------------------------
// Fixed-point ALU package
// Word format, command codes, status codes and the pipeline word type.
// ----------------------------------------------------------------------------
package fpa_pkg;

   localparam int WordBits = 32;
   localparam int FracBits = 18;
   localparam int DivBits  = WordBits + FracBits;  // dividend and quotient width

   localparam int CmdBits     = 4;
   localparam int StatusBits  = 2;
   localparam int ReqDataBits = 72;                // command, operand_a, operand_b
   localparam int RspDataBits = 40;                // result_word, less_than, equal_flag, status

   localparam logic [CmdBits-1:0] CMD_ADD      = 4'd0;
   localparam logic [CmdBits-1:0] CMD_SUB      = 4'd1;
   localparam logic [CmdBits-1:0] CMD_MUL      = 4'd2;
   localparam logic [CmdBits-1:0] CMD_DIV      = 4'd3;
   localparam logic [CmdBits-1:0] CMD_NEG      = 4'd4;
   localparam logic [CmdBits-1:0] CMD_ABS      = 4'd5;
   localparam logic [CmdBits-1:0] CMD_SIGN     = 4'd6;
   localparam logic [CmdBits-1:0] CMD_FRAC     = 4'd7;
   localparam logic [CmdBits-1:0] CMD_COMPARE  = 4'd8;
   localparam logic [CmdBits-1:0] CMD_FROM_INT = 4'd9;

   localparam logic [StatusBits-1:0] STATUS_OK       = 2'd0;
   localparam logic [StatusBits-1:0] STATUS_DIV_ZERO = 2'd1;
   localparam logic [StatusBits-1:0] STATUS_NEG_UNS  = 2'd2;

   localparam logic [WordBits-1:0] OneFx    = WordBits'(1) << FracBits;
   localparam logic [WordBits-1:0] FracMask = OneFx - WordBits'(1);

   // word carried beside the divider
   typedef struct packed {
      logic                  is_div;
      logic                  neg_q;
      logic [WordBits-1:0]   res;
      logic                  lt;
      logic                  eq;
      logic [StatusBits-1:0] st;
   } pay_type;

endpackage

>>> rtl/fpa_div.sv
// ----------------------------------------------------------------------------
// Fixed-point ALU divider
// Restoring unsigned divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module fpa_div
   import fpa_pkg::*;
(
   input  logic                clock,
   input  logic                enable,
   input  logic [DivBits-1:0]  dividend,
   input  logic [WordBits-1:0] divisor,
   output logic [DivBits-1:0]  quotient
);

   logic [WordBits-1:0] rem_ff [DivBits];
   logic [DivBits-1:0]  nq_ff  [DivBits];
   logic [WordBits-1:0] den_ff [DivBits];

   for (genvar k = 0; k < DivBits; k++) begin : g_step
      logic [WordBits-1:0] rem_src;
      logic [DivBits-1:0]  nq_src;
      logic [WordBits-1:0] den_src;
      logic [WordBits:0]   trial;
      logic [WordBits:0]   diff;
      logic [WordBits-1:0] rem_in;
      logic [DivBits-1:0]  nq_in;

      if (k == 0) begin : g_first
         assign rem_src = '0;
         assign nq_src  = dividend;
         assign den_src = divisor;
      end else begin : g_next
         assign rem_src = rem_ff[k-1];
         assign nq_src  = nq_ff[k-1];
         assign den_src = den_ff[k-1];
      end

      // shift in the next dividend bit, subtract when it fits
      always_comb begin
         trial  = {rem_src, nq_src[DivBits-1]};
         diff   = trial - {1'b0, den_src};
         rem_in = diff[WordBits] ? trial[WordBits-1:0] : diff[WordBits-1:0];
         nq_in  = {nq_src[DivBits-2:0], ~diff[WordBits]};
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[k] <= rem_in;
            nq_ff[k]  <= nq_in;
            den_ff[k] <= den_src;
         end
      end
   end

   assign quotient = nq_ff[DivBits-1];

endmodule

>>> rtl/fixed_point_alu.sv
// ----------------------------------------------------------------------------
// Fixed-point ALU
// Pipelined Q-format ALU: add, sub, mul, div, neg, abs, sign, frac, compare,
// integer-to-fixed, with a signed/unsigned mode register.
// ----------------------------------------------------------------------------
// One word enters per cycle unless the pipe holds, and every command takes the
// same path, so results leave in order. The path is an input register, an
// operand stage holding two partial products (33x16 and 33x17 bits) and the
// magnitude logic, 50 divider stages (one quotient bit each, the 50-bit shifted
// dividend sets the depth; the side line sums the partial products in its first
// stage), and the output register. A two-entry output buffer (output register
// plus skid) lets the pipe keep taking words while a result waits; only when
// both entries are full does the whole pipe hold. The mode register is sampled
// by the operand stage, so write it only while the ALU is empty.
// ----------------------------------------------------------------------------
module fixed_point_alu
   import fpa_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // request: [3:0] command, [35:4] operand_a, [67:36] operand_b, rest zero
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [ReqDataBits-1:0] req_tdata,
   // response: [31:0] result_word, [32] less_than, [33] equal_flag,
   // [35:34] status, rest zero
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RspDataBits-1:0] rsp_tdata,
   // mode register write: signed_mode
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic                   csr_wdata
);

   localparam int RspPad   = RspDataBits - WordBits - 2 - StatusBits;
   localparam int HalfBits = WordBits / 2;
   localparam int PhBits   = DivBits - HalfBits;

   logic adv;            // whole pipe advances
   logic signed_mode_ff;

   // input register
   logic                v0_ff;
   logic [CmdBits-1:0]  cmd0_ff;
   logic [WordBits-1:0] a0_ff, b0_ff;

   // operand stage
   logic                  v1_ff;
   pay_type               pay1_ff, pay1_in;
   logic                  mul1_ff, mul1_in;
   logic [DivBits-1:0]    pl1_ff;
   logic signed [DivBits-1:0] pl1_in;
   logic [PhBits-1:0]     ph1_ff;
   logic signed [PhBits-1:0]  ph1_in;
   logic [DivBits-1:0]    dvd1_ff, dvd1_in;
   logic [WordBits-1:0]   dvs1_ff, dvs1_in;

   // side line beside the divider
   pay_type             side_ff [DivBits];
   logic [DivBits-1:0]  side_v_ff;
   pay_type             side0_in;
   logic [DivBits-1:0]  quotient;

   // output buffer
   logic                  out_v_ff, skid_v_ff;
   logic [RspDataBits-1:0] out_ff, skid_ff, fin_in;
   logic [WordBits-1:0]   q_low;

   assign adv        = ~skid_v_ff;
   assign req_tready = adv;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_ff;

   // mode register
   always_ff @(posedge clock) begin
      if (reset) begin
         signed_mode_ff <= 1'b1;
      end else if (csr_valid) begin
         signed_mode_ff <= csr_wdata;
      end
   end

   // input register: capture the request word
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (adv) begin
         v0_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cmd0_ff <= req_tdata[CmdBits-1:0];
         a0_ff   <= req_tdata[CmdBits +: WordBits];
         b0_ff   <= req_tdata[CmdBits+WordBits +: WordBits];
      end
   end

   // operand stage: all commands but multiply and divide, partial products, divider setup
   always_comb begin
      logic                     a_neg, b_neg;
      logic [WordBits-1:0]      neg_a, abs_a;
      logic signed [WordBits:0] a_x, b_x;
      logic signed [HalfBits:0] b_lo_s, b_hi_s;

      a_neg     = signed_mode_ff & a0_ff[WordBits-1];
      b_neg     = signed_mode_ff & b0_ff[WordBits-1];
      neg_a     = -a0_ff;
      abs_a     = a_neg ? neg_a : a0_ff;
      // widen by one bit: sign in signed mode, zero in unsigned mode
      a_x       = {a_neg, a0_ff};
      b_x       = {b_neg, b0_ff};
      // split b into an unsigned low half and a signed high half
      b_lo_s    = {1'b0, b0_ff[HalfBits-1:0]};
      b_hi_s    = b_x[WordBits:HalfBits];
      // keep only the product bits that reach the result
      pl1_in    = DivBits'(a_x) * DivBits'(b_lo_s);
      ph1_in    = PhBits'(a_x) * PhBits'(b_hi_s);
      dvd1_in   = {abs_a, {FracBits{1'b0}}};
      dvs1_in   = b_neg ? -b0_ff : b0_ff;
      mul1_in   = 1'b0;

      pay1_in        = '0;
      pay1_in.st     = STATUS_OK;
      unique case (cmd0_ff)
         CMD_ADD: begin
            pay1_in.res = a0_ff + b0_ff;
         end
         CMD_SUB: begin
            pay1_in.res = a0_ff - b0_ff;
         end
         CMD_MUL: begin
            mul1_in = 1'b1;
         end
         CMD_DIV: begin
            if (b0_ff == '0) begin
               pay1_in.st = STATUS_DIV_ZERO;
            end else begin
               pay1_in.is_div = 1'b1;
               pay1_in.neg_q  = a_neg ^ b_neg;
            end
         end
         CMD_NEG: begin
            if (signed_mode_ff) begin
               pay1_in.res = neg_a;
            end else begin
               pay1_in.st = STATUS_NEG_UNS;
            end
         end
         CMD_ABS: begin
            pay1_in.res = abs_a;
         end
         CMD_SIGN: begin
            if (signed_mode_ff) begin
               pay1_in.res = a0_ff[WordBits-1] ? -OneFx : OneFx;
            end else begin
               pay1_in.res = (a0_ff == '0) ? '0 : OneFx;
            end
         end
         CMD_FRAC: begin
            pay1_in.res = abs_a & FracMask;
         end
         CMD_COMPARE: begin
            pay1_in.eq = (a0_ff == b0_ff);
            // in signed mode, flip the sign bits to compare two's complement as unsigned
            pay1_in.lt = ({a0_ff[WordBits-1] ^ signed_mode_ff, a0_ff[WordBits-2:0]} <
                          {b0_ff[WordBits-1] ^ signed_mode_ff, b0_ff[WordBits-2:0]});
         end
         CMD_FROM_INT: begin
            pay1_in.res = a0_ff << FracBits;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= v0_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pay1_ff  <= pay1_in;
         mul1_ff  <= mul1_in;
         pl1_ff   <= pl1_in;
         ph1_ff   <= ph1_in;
         dvd1_ff  <= dvd1_in;
         dvs1_ff  <= dvs1_in;
      end
   end

   // divider, one quotient bit a stage
   fpa_div u_div (
      .clock    (clock),
      .enable   (adv),
      .dividend (dvd1_ff),
      .divisor  (dvs1_ff),
      .quotient (quotient)
   );

   // side line: sum the partial products for a multiply, then delay to match
   // the divider
   always_comb begin
      logic [DivBits-1:0] prod;
      side0_in = pay1_ff;
      prod     = pl1_ff + {ph1_ff, {HalfBits{1'b0}}};
      if (mul1_ff) begin
         side0_in.res = prod[FracBits +: WordBits];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_v_ff <= '0;
      end else if (adv) begin
         side_v_ff <= {side_v_ff[DivBits-2:0], v1_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= side0_in;
         for (int k = 1; k < DivBits; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   // final select: apply the quotient sign for divides
   always_comb begin
      pay_type last;
      last  = side_ff[DivBits-1];
      q_low = quotient[WordBits-1:0];
      if (last.is_div) begin
         last.res = last.neg_q ? -q_low : q_low;
      end
      fin_in = {{RspPad{1'b0}}, last.st, last.eq, last.lt, last.res};
   end

   // output register plus skid entry
   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (!out_v_ff || rsp_tready) begin
         if (skid_v_ff) begin
            out_v_ff  <= 1'b1;
            skid_v_ff <= 1'b0;
         end else begin
            out_v_ff  <= side_v_ff[DivBits-1];
         end
      end else if (side_v_ff[DivBits-1]) begin
         skid_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_v_ff || rsp_tready) begin
         out_ff <= skid_v_ff ? skid_ff : fin_in;
      end else if (adv) begin
         skid_ff <= fin_in;
      end
   end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Fixed-point ALU testbench
// Streams directed and random commands through the ALU under both signedness
// modes, with random gaps on both sides and one long output stall, and checks
// every response word against an in-bench model of the arithmetic.
// ----------------------------------------------------------------------------
module testbench;
   import fpa_pkg::*;

   // packed from the top bit down, so the last member sits at bit 0
   typedef struct packed {
      logic [StatusBits-1:0] st;
      logic                  eq;
      logic                  lt;
      logic [WordBits-1:0]   res;
   } alu_rsp_t;

   typedef struct packed {
      logic [CmdBits-1:0]  cmd;
      logic [WordBits-1:0] a;
      logic [WordBits-1:0] b;
   } alu_req_t;

   localparam logic [WordBits-1:0] SignBit = WordBits'(1) << (WordBits - 1);
   localparam int RspUsed  = $bits(alu_rsp_t);
   localparam int StallLen = 400;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [ReqDataBits-1:0] req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RspDataBits-1:0] rsp_tdata;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic                   csr_wdata = 1'b0;

   alu_req_t pending_reqs[$];
   alu_rsp_t expected_rsps[$];
   logic     mode_signed = 1'b1;   // bench copy of signed_mode
   int       fail_count  = 0;
   logic     stall_go    = 1'b0;    // asks for the long output hold-off
   logic     stall_armed = 1'b1;
   int       stall_left  = 0;       // long output hold-off, in cycles
   logic     req_tready_q = 1'b0;
   logic     rsp_taken   = 1'b0;
   int       req_gap     = 0;
   int       rsp_gap     = 0;

   fixed_point_alu u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // Compute the response word for one command under the current mode.
   function automatic alu_rsp_t alu_predict(alu_req_t r, logic sgn);
      alu_rsp_t o;
      logic [63:0] p, q, ma, mb;
      logic [WordBits-1:0] ma32, mb32;
      logic na, nb;
      o = '0;
      na = r.a[WordBits-1];
      nb = r.b[WordBits-1];
      case (r.cmd)
         CMD_ADD: o.res = r.a + r.b;
         CMD_SUB: o.res = r.a - r.b;
         CMD_MUL: begin
            if (sgn) begin
               p = $signed({{32{na}}, r.a}) * $signed({{32{nb}}, r.b});
               o.res = WordBits'($signed(p) >>> FracBits);
            end else begin
               p = {32'd0, r.a} * {32'd0, r.b};
               o.res = WordBits'(p >> FracBits);
            end
         end
         CMD_DIV: begin
            if (r.b == '0) begin
               o.st = STATUS_DIV_ZERO;
            end else if (sgn) begin
               ma32 = na ? -r.a : r.a;
               mb32 = nb ? -r.b : r.b;
               ma = {32'd0, ma32};
               mb = {32'd0, mb32};
               q = (ma << FracBits) / mb;
               o.res = WordBits'((na != nb) ? -q : q);
            end else begin
               q = (64'(r.a) << FracBits) / 64'(r.b);
               o.res = WordBits'(q);
            end
         end
         CMD_NEG: begin
            if (sgn) o.res = -r.a;
            else o.st = STATUS_NEG_UNS;
         end
         CMD_ABS:  o.res = (sgn && na) ? -r.a : r.a;
         CMD_SIGN: begin
            if (sgn) o.res = na ? -OneFx : OneFx;
            else o.res = (r.a == '0) ? '0 : OneFx;
         end
         CMD_FRAC: o.res = ((sgn && na) ? -r.a : r.a) & FracMask;
         CMD_COMPARE: begin
            o.eq = (r.a == r.b);
            o.lt = sgn ? ((r.a ^ SignBit) < (r.b ^ SignBit)) : (r.a < r.b);
         end
         CMD_FROM_INT: o.res = r.a << FracBits;
         default: ;
      endcase
      return o;
   endfunction

   function automatic logic [WordBits-1:0] pick_word();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         2: return SignBit;
         3: return SignBit - WordBits'(1);
         4: return OneFx;
         5: return WordBits'($urandom_range(0, 15)) << $urandom_range(0, 31);
         6: return -WordBits'($urandom_range(0, 1 << 20));
         default: return $urandom;
      endcase
   endfunction

   // Latch the accept at the rising edge so the driver sees a settled value.
   always @(posedge clock) req_tready_q <= req_tvalid && req_tready;

   // Driver: hold a word until taken, then wait the gap drawn for the next.
   always @(negedge clock) begin
      if (!reset) begin
         if (req_tvalid && !req_tready_q) begin
            // hold the offered word
         end else if (req_gap > 0) begin
            req_tvalid <= 1'b0;
            req_gap    <= req_gap - 1;
         end else if (pending_reqs.size() > 0) begin
            req_tdata  <= ReqDataBits'({pending_reqs[0].b, pending_reqs[0].a,
                                        pending_reqs[0].cmd});
            expected_rsps.push_back(alu_predict(pending_reqs[0], mode_signed));
            void'(pending_reqs.pop_front());
            req_tvalid <= 1'b1;
            req_gap    <= $urandom_range(0, 9);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Long hold-off counter, started once on request.
   always @(negedge clock) begin
      if (stall_go && stall_armed) begin
         stall_left  <= StallLen;
         stall_armed <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
      end
   end

   // Receiver readiness: random gaps, or a long hold when requested.
   always @(negedge clock) begin
      int g;
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_tready <= 1'b0;
         rsp_gap    <= rsp_gap - 1;
      end else if (rsp_tready && rsp_taken) begin
         g = $urandom_range(0, 9);
         if (g > 0) begin
            rsp_tready <= 1'b0;
            rsp_gap    <= g - 1;
         end
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Monitor: compare each accepted response with the oldest expectation.
   always @(posedge clock) begin
      alu_rsp_t got, exp_r;
      rsp_taken <= 1'b0;
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsp_taken <= 1'b1;
         got = alu_rsp_t'(rsp_tdata[RspUsed-1:0]);
         if (expected_rsps.size() == 0) begin
            $error("unexpected response word %h", rsp_tdata);
            fail_count++;
         end else begin
            exp_r = expected_rsps.pop_front();
            if (got.res !== exp_r.res) begin
               $error("result_word expected %h actual %h", exp_r.res, got.res);
               fail_count++;
            end
            if (got.lt !== exp_r.lt) begin
               $error("less_than expected %b actual %b", exp_r.lt, got.lt);
               fail_count++;
            end
            if (got.eq !== exp_r.eq) begin
               $error("equal_flag expected %b actual %b", exp_r.eq, got.eq);
               fail_count++;
            end
            if (got.st !== exp_r.st) begin
               $error("status expected %d actual %d", exp_r.st, got.st);
               fail_count++;
            end
            if (rsp_tdata[RspDataBits-1:RspUsed] !== '0) begin
               $error("pad bits expected 0 actual %h", rsp_tdata[RspDataBits-1:RspUsed]);
               fail_count++;
            end
         end
      end
   end

   // Block until every queued word has been sent and answered.
   task automatic wait_drained();
      while (!(pending_reqs.size() == 0 && !req_tvalid && expected_rsps.size() == 0))
         @(negedge clock);
   endtask

   // Wait until the ALU has drained, then write the mode register.
   task automatic write_mode(logic m);
      wait_drained();
      repeat (60) @(negedge clock);
      csr_wdata <= m;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid   <= 1'b0;
      mode_signed = m;
   endtask

   task automatic queue_req(logic [CmdBits-1:0] c, logic [WordBits-1:0] a,
                            logic [WordBits-1:0] b);
      alu_req_t r;
      r.cmd = c; r.a = a; r.b = b;
      pending_reqs.push_back(r);
   endtask

   initial begin
      logic [CmdBits-1:0] c;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: every command at the word extremes, signed mode from reset.
      for (int k = 0; k <= 9; k++) queue_req(CMD_ADD + CmdBits'(k), SignBit, '1);
      queue_req(CMD_DIV, OneFx, '0);         // divide by zero
      queue_req(CMD_SIGN, '0, '0);            // zero gives +1.0 when signed
      queue_req(CMD_COMPARE, 32'h1234, 32'h1234);
      queue_req(CMD_MUL, '1, '1);
      queue_req(4'd15, '1, '1);               // unused code
      write_mode(1'b0);
      queue_req(CMD_NEG, 32'd5, '0);          // negate unsupported unsigned
      queue_req(CMD_SIGN, '0, '1);
      queue_req(CMD_DIV, '1, 32'd1);
      queue_req(CMD_MUL, '1, '1);
      queue_req(CMD_COMPARE, SignBit, 32'd1);
      queue_req(4'd10, '0, '0);

      // Random phases alternating mode; one phase stalls the output for long.
      for (int ph = 0; ph < 8; ph++) begin
         write_mode(ph[0]);
         if (ph == 3) stall_go = 1'b1;
         for (int i = 0; i < 250; i++) begin
            c = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(10, 15))
                                              : 4'($urandom_range(0, 9));
            queue_req(c, pick_word(), pick_word());
         end
      end
      wait_drained();
      repeat (100) @(posedge clock);
      if (fail_count == 0 && expected_rsps.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("status: fail");
      $finish;
   end

endmodule
